// ===== rtl/dual_motor_pwm_ramp_assert.svh =====
// Assertion macros shared by the RTL of the dual motor PWM ramp.
// DMPR_ASSERT_NOW checks the consequence in the same cycle as the condition.
// DMPR_ASSERT_NEXT checks the consequence in the cycle after the condition.
// Defining ASSERT_OFF removes every assertion from the design.
`ifndef DUAL_MOTOR_PWM_RAMP_ASSERT_SVH
`define DUAL_MOTOR_PWM_RAMP_ASSERT_SVH

`ifndef ASSERT_OFF

`define DMPR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dual_motor_pwm_ramp: assertion failed");

`define DMPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dual_motor_pwm_ramp: assertion failed");

`else

`define DMPR_ASSERT_NOW(lbl, clk, rstn, ante, cons)

`define DMPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/dmpr_pkg.sv =====
`default_nettype none

package dmpr_pkg;

    // Item kinds.
    localparam logic [1:0] KIND_SET_TARGET = 2'd0;
    localparam logic [1:0] KIND_TICK       = 2'd1;
    localparam logic [1:0] KIND_SET_DIR    = 2'd2;
    localparam logic [1:0] KIND_UNUSED     = 2'd3;

    // Motor selection.
    localparam logic [1:0] SEL_LEFT  = 2'd0;
    localparam logic [1:0] SEL_RIGHT = 2'd1;
    localparam logic [1:0] SEL_BOTH  = 2'd2;
    localparam logic [1:0] SEL_NONE  = 2'd3;

    // Direction codes.
    localparam logic [1:0] DIR_FORWARD  = 2'd0;
    localparam logic [1:0] DIR_BACKWARD = 2'd1;
    localparam logic [1:0] DIR_STOP     = 2'd2;
    localparam logic [1:0] DIR_IGNORE   = 2'd3;

    // Pin levels for one motor: bit 0 forward, bit 1 backward.
    localparam logic [1:0] PINS_FORWARD  = 2'b01;
    localparam logic [1:0] PINS_BACKWARD = 2'b10;
    localparam logic [1:0] PINS_OFF      = 2'b00;

    localparam logic [15:0] PERIOD_RESET = 16'd1000;
    localparam logic [6:0]  FULL_PERCENT = 7'd100;

    // floor(x / 100) equals (x * DUTY_RECIP) >> SCALE_SHIFT for every
    // x = period * duty that can occur (x below 2^23).
    localparam int unsigned DUTY_RECIP  = 32'd10737419;
    localparam int unsigned SCALE_SHIFT = 30;

    typedef logic [30:0] scale_t;
    typedef scale_t scale_table_t [128];

    function automatic scale_table_t build_scale_table();
        scale_table_t tbl;
        for (int i = 0; i < 128; i++) begin
            tbl[i] = 31'(longint'(i) * longint'(DUTY_RECIP));
        end
        return tbl;
    endfunction

    // Duty times the reciprocal of 100, one entry per duty value.
    localparam scale_table_t SCALE_TABLE = build_scale_table();

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] motor_select;
        logic [7:0] target_percent;
        logic [1:0] direction;
    } in_item_t;

    typedef struct packed {
        logic [15:0] left_compare;
        logic [15:0] right_compare;
        logic        left_enable;
        logic        right_enable;
        logic        left_forward_pin;
        logic        left_backward_pin;
        logic        right_forward_pin;
        logic        right_backward_pin;
        logic        ramp_busy;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/dual_motor_pwm_ramp.sv =====
// Channel   Direction  Handshake                 Payload
// s_        in         s_valid / s_ready         s_item   (dmpr_pkg::in_item_t)
// m_        out        m_valid / m_ready         m_item   (dmpr_pkg::out_item_t)
// cfg_      in         cfg_valid / cfg_ready     cfg_data (period_ticks, 16 bits)
//
// One item per clock cycle is sustained while m_ready stays high. Each item passes
// from the input register through a single compute stage into the result register;
// in the compute stage each motor channel has its own duty-to-compare multiplier.
// Reset (aresetn low, synchronous) zeroes all duty, compare, enable, pin and busy
// state and loads the period with 1000; no clearing pass is needed.
// A stalled result holds the compute stage, and the input register then holds one more item.
`default_nettype none

`include "dual_motor_pwm_ramp_assert.svh"

module dual_motor_pwm_ramp (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire dmpr_pkg::in_item_t  s_item,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output dmpr_pkg::out_item_t      m_item,

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [15:0]         cfg_data
);

    // The period register accepts a write on every cycle. The user must write it only while the
    // block is idle (not enforced by the block), so no item is converted with a half-updated period.
    logic [15:0] period_reg;

    // Input register: one item waiting for the compute stage.
    logic                 in_valid_reg;
    logic                 in_valid_next;
    dmpr_pkg::in_item_t   in_item_reg;

    // Result register.
    logic                 m_valid_reg;
    logic                 m_valid_next;
    dmpr_pkg::out_item_t  m_item_reg;
    dmpr_pkg::out_item_t  m_item_next;

    // Per-channel state; index 0 is the left motor, index 1 the right motor.
    logic [6:0]  duty_now_reg   [2];
    logic [6:0]  duty_now_next  [2];
    logic [6:0]  duty_goal_reg  [2];
    logic [6:0]  duty_goal_next [2];
    logic [15:0] compare_reg    [2];
    logic [15:0] compare_next   [2];
    logic [1:0]  enable_reg;
    logic [1:0]  enable_next;
    // Pins: bit 0 left forward, bit 1 left backward, bit 2 right forward, bit 3 right backward.
    logic [3:0]  pins_reg;
    logic [3:0]  pins_next;
    logic        busy_reg;
    logic        busy_next;

    // Compute-stage control.
    logic        proc;
    logic        is_set;
    logic        is_tick;
    logic        is_dir;
    logic [1:0]  sel_hit;
    logic [1:0]  moved;
    logic [6:0]  target_clamped;
    logic [1:0]  pin_level;
    logic        pin_write;
    logic [46:0] scaled [2];

    // The compute stage runs whenever it holds an item and the result register is free
    // or being emptied in the same cycle.
    assign proc      = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign cfg_ready = 1'b1;

    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !proc);
    assign m_valid_next  = proc || (m_valid_reg && !m_ready);

    always_comb begin
        is_set  = (in_item_reg.kind == dmpr_pkg::KIND_SET_TARGET);
        is_tick = (in_item_reg.kind == dmpr_pkg::KIND_TICK);
        is_dir  = (in_item_reg.kind == dmpr_pkg::KIND_SET_DIR);

        // Selecting no motor hits neither channel.
        sel_hit[0] = (in_item_reg.motor_select == dmpr_pkg::SEL_LEFT) ||
                     (in_item_reg.motor_select == dmpr_pkg::SEL_BOTH);
        sel_hit[1] = (in_item_reg.motor_select == dmpr_pkg::SEL_RIGHT) ||
                     (in_item_reg.motor_select == dmpr_pkg::SEL_BOTH);

        // Targets above full duty are clamped to full duty.
        if (in_item_reg.target_percent > 8'(dmpr_pkg::FULL_PERCENT)) begin
            target_clamped = dmpr_pkg::FULL_PERCENT;
        end else begin
            target_clamped = in_item_reg.target_percent[6:0];
        end

        // The ignored direction leaves the pins as they are.
        pin_write = 1'b1;
        unique case (in_item_reg.direction)
            dmpr_pkg::DIR_FORWARD: begin
                pin_level = dmpr_pkg::PINS_FORWARD;
            end
            dmpr_pkg::DIR_BACKWARD: begin
                pin_level = dmpr_pkg::PINS_BACKWARD;
            end
            dmpr_pkg::DIR_STOP: begin
                pin_level = dmpr_pkg::PINS_OFF;
            end
            default: begin
                pin_level = dmpr_pkg::PINS_OFF;
                pin_write = 1'b0;
            end
        endcase

        for (int c = 0; c < 2; c++) begin
            moved[c] = is_tick && (duty_now_reg[c] != duty_goal_reg[c]);

            // A moving channel steps one percent toward its goal.
            duty_now_next[c] = duty_now_reg[c];
            if (moved[c]) begin
                if (duty_goal_reg[c] < duty_now_reg[c]) begin
                    duty_now_next[c] = duty_now_reg[c] - 7'd1;
                end else begin
                    duty_now_next[c] = duty_now_reg[c] + 7'd1;
                end
            end

            if (is_set && sel_hit[c]) begin
                duty_goal_next[c] = target_clamped;
            end else begin
                duty_goal_next[c] = duty_goal_reg[c];
            end

            // period * duty / 100 through the reciprocal table, then
            // compare = period - share - 1, wrapping at 16 bits. Full duty and a
            // zero period both wrap to all ones.
            scaled[c] = 47'(period_reg) * 47'(dmpr_pkg::SCALE_TABLE[duty_now_next[c]]);
            if (moved[c]) begin
                compare_next[c] = period_reg
                                - scaled[c][dmpr_pkg::SCALE_SHIFT +: 16]
                                - 16'd1;
                enable_next[c]  = (duty_now_next[c] != 7'd0);
            end else begin
                compare_next[c] = compare_reg[c];
                enable_next[c]  = enable_reg[c];
            end

            if (is_dir && sel_hit[c] && pin_write) begin
                pins_next[2*c +: 2] = pin_level;
            end else begin
                pins_next[2*c +: 2] = pins_reg[2*c +: 2];
            end
        end

        // A set-target item raises busy even when no motor is selected; a tick that
        // moves neither channel clears it.
        priority if (is_set) begin
            busy_next = 1'b1;
        end else if (is_tick && (moved == 2'b00)) begin
            busy_next = 1'b0;
        end else begin
            busy_next = busy_reg;
        end

        m_item_next.left_compare       = compare_next[0];
        m_item_next.right_compare      = compare_next[1];
        m_item_next.left_enable        = enable_next[0];
        m_item_next.right_enable       = enable_next[1];
        m_item_next.left_forward_pin   = pins_next[0];
        m_item_next.left_backward_pin  = pins_next[1];
        m_item_next.right_forward_pin  = pins_next[2];
        m_item_next.right_backward_pin = pins_next[3];
        m_item_next.ramp_busy          = busy_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= dmpr_pkg::PERIOD_RESET;
            in_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                duty_now_reg[c]  <= 7'd0;
                duty_goal_reg[c] <= 7'd0;
                compare_reg[c]   <= 16'd0;
            end
            enable_reg    <= 2'b00;
            pins_reg      <= 4'b0000;
            busy_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                period_reg <= cfg_data;
            end
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (proc) begin
                for (int c = 0; c < 2; c++) begin
                    duty_now_reg[c]  <= duty_now_next[c];
                    duty_goal_reg[c] <= duty_goal_next[c];
                    compare_reg[c]   <= compare_next[c];
                end
                enable_reg <= enable_next;
                pins_reg   <= pins_next;
                busy_reg   <= busy_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (proc) begin
            m_item_reg <= m_item_next;
        end
    end

    `DMPR_ASSERT_NOW(a_duty_in_range, aclk, aresetn, 1'b1, (duty_now_reg[0] <= dmpr_pkg::FULL_PERCENT) && (duty_now_reg[1] <= dmpr_pkg::FULL_PERCENT))
    `DMPR_ASSERT_NOW(a_enable_tracks_duty, aclk, aresetn, 1'b1, (enable_reg[0] == (duty_now_reg[0] != 7'd0)) && (enable_reg[1] == (duty_now_reg[1] != 7'd0)))
    `DMPR_ASSERT_NEXT(a_compare_only_on_tick, aclk, aresetn, !(proc && is_tick), $stable(compare_reg[0]) && $stable(compare_reg[1]))
    `DMPR_ASSERT_NEXT(a_set_raises_busy, aclk, aresetn, proc && is_set, busy_reg && m_valid_reg)

endmodule

`default_nettype wire

// ===== bench/dual_motor_pwm_ramp_tb.sv =====
module dual_motor_pwm_ramp_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // A result passes through the input register and the result register, so settling
    // for SETTLE_CYCLES after the last result is plenty to catch a stray one.
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PRINT_LIMIT   = 100;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    dmpr_pkg::in_item_t  s_item    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    dmpr_pkg::out_item_t m_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [15:0]         cfg_data  = '0;

    dual_motor_pwm_ramp uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Items waiting to be sent, and the results the drive model predicts
    // for items already transferred, oldest first.
    dmpr_pkg::in_item_t  pending_q[$];
    dmpr_pkg::out_item_t expected_q[$];

    int unsigned items_queued  = 0;
    int unsigned results_seen  = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int          send_gap      = 0;
    int          recv_hold     = 0;
    bit          steady_mode   = 1'b0;

    // Drive model state. Index 0 is the left motor and index 1 the right one.
    logic [15:0] period_cur = dmpr_pkg::PERIOD_RESET;
    logic [6:0]  duty_now  [2] = '{7'd0, 7'd0};
    logic [6:0]  duty_goal [2] = '{7'd0, 7'd0};
    logic [15:0] cmp_val   [2] = '{16'd0, 16'd0};
    logic        pwm_en    [2] = '{1'b0, 1'b0};
    logic [1:0]  pin_level [2] = '{dmpr_pkg::PINS_OFF, dmpr_pkg::PINS_OFF};
    logic        ramp_busy = 1'b0;

    // Compare value for a duty in percent under the current period. The
    // subtraction wraps, so full duty and a zero period both give all ones.
    function automatic logic [15:0] compare_for(input logic [6:0] duty);
        logic [31:0] share;
        share = (32'(period_cur) * 32'(duty)) / 32'(dmpr_pkg::FULL_PERCENT);
        return 16'(32'(period_cur) - share - 32'd1);
    endfunction

    // Applies one transferred item to the drive model and returns the
    // result the block must show for it.
    task automatic predict_item(input dmpr_pkg::in_item_t it,
                                output dmpr_pkg::out_item_t res);
        logic [1:0] hit;
        logic [7:0] want;
        logic [1:0] lvl;
        logic       dir_ok;
        logic       moved;
        hit[0] = (it.motor_select == dmpr_pkg::SEL_LEFT) ||
                 (it.motor_select == dmpr_pkg::SEL_BOTH);
        hit[1] = (it.motor_select == dmpr_pkg::SEL_RIGHT) ||
                 (it.motor_select == dmpr_pkg::SEL_BOTH);
        case (it.kind)
            dmpr_pkg::KIND_SET_TARGET: begin
                want = (it.target_percent > dmpr_pkg::FULL_PERCENT)
                     ? 8'(dmpr_pkg::FULL_PERCENT) : it.target_percent;
                for (int m = 0; m < 2; m++) begin
                    if (hit[m]) duty_goal[m] = want[6:0];
                end
                // Busy rises even when no motor is selected.
                ramp_busy = 1'b1;
            end
            dmpr_pkg::KIND_TICK: begin
                moved = 1'b0;
                for (int m = 0; m < 2; m++) begin
                    if (duty_now[m] != duty_goal[m]) begin
                        if (duty_goal[m] < duty_now[m]) duty_now[m] = duty_now[m] - 7'd1;
                        else duty_now[m] = duty_now[m] + 7'd1;
                        cmp_val[m] = compare_for(duty_now[m]);
                        pwm_en[m]  = (duty_now[m] != 7'd0);
                        moved      = 1'b1;
                    end
                end
                if (!moved) ramp_busy = 1'b0;
            end
            dmpr_pkg::KIND_SET_DIR: begin
                dir_ok = 1'b1;
                case (it.direction)
                    dmpr_pkg::DIR_FORWARD:  lvl = dmpr_pkg::PINS_FORWARD;
                    dmpr_pkg::DIR_BACKWARD: lvl = dmpr_pkg::PINS_BACKWARD;
                    dmpr_pkg::DIR_STOP:     lvl = dmpr_pkg::PINS_OFF;
                    default: begin
                        lvl    = dmpr_pkg::PINS_OFF;
                        dir_ok = 1'b0;
                    end
                endcase
                for (int m = 0; m < 2; m++) begin
                    if (hit[m] && dir_ok) pin_level[m] = lvl;
                end
            end
            default: ;
        endcase
        res.left_compare       = cmp_val[0];
        res.right_compare      = cmp_val[1];
        res.left_enable        = pwm_en[0];
        res.right_enable       = pwm_en[1];
        res.left_forward_pin   = pin_level[0][0];
        res.left_backward_pin  = pin_level[0][1];
        res.right_forward_pin  = pin_level[1][0];
        res.right_backward_pin = pin_level[1][1];
        res.ramp_busy          = ramp_busy;
    endtask

    // Mostly back-to-back traffic, some short gaps and a few long ones; none in steady mode.
    function automatic int pick_gap();
        int r;
        if (steady_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("result %0d %s: got %0h, expected %0h",
                                   results_seen, name, got, want));
        end
    endtask

    function automatic dmpr_pkg::in_item_t make_item(input logic [1:0] kind,
                                                     input logic [1:0] sel,
                                                     input logic [7:0] tgt,
                                                     input logic [1:0] dir);
        dmpr_pkg::in_item_t it;
        it.kind           = kind;
        it.motor_select   = sel;
        it.target_percent = tgt;
        it.direction      = dir;
        return it;
    endfunction

    task automatic enqueue(input dmpr_pkg::in_item_t it);
        pending_q.push_back(it);
        items_queued++;
    endtask

    // One random stretch of traffic. Most of it is a ramp: a new goal for
    // some motor, maybe a direction change, then a run of ticks that is
    // sometimes long enough to sweep the full duty range and settle. The
    // rest is raw noise, which includes the unused kind.
    task automatic queue_burst();
        int         pick;
        int         ticks;
        logic [7:0] goal;
        pick = $urandom_range(0, 99);
        if (pick < 82) begin
            for (int g = 0; g < (($urandom_range(0, 2) == 0) ? 2 : 1); g++) begin
                case ($urandom_range(0, 5))
                    0:       goal = 8'd0;
                    1:       goal = 8'(dmpr_pkg::FULL_PERCENT);
                    2:       goal = 8'($urandom_range(101, 255));
                    default: goal = 8'($urandom_range(0, 100));
                endcase
                enqueue(make_item(dmpr_pkg::KIND_SET_TARGET,
                                  ($urandom_range(0, 9) == 0) ? dmpr_pkg::SEL_NONE
                                                              : 2'($urandom_range(0, 2)),
                                  goal, 2'($urandom)));
            end
            if ($urandom_range(0, 3) == 0) begin
                enqueue(make_item(dmpr_pkg::KIND_SET_DIR, 2'($urandom), 8'($urandom),
                                  2'($urandom)));
            end
            ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(95, 110)
                                                : $urandom_range(1, 25);
            repeat (ticks) begin
                enqueue(make_item(dmpr_pkg::KIND_TICK, 2'($urandom), 8'($urandom),
                                  2'($urandom)));
            end
        end else begin
            repeat ($urandom_range(1, 4)) enqueue(dmpr_pkg::in_item_t'(14'($urandom)));
        end
    endtask

    // Returns once the sender is empty and every predicted result has been
    // checked, then lets the pipeline settle. The check is made at the
    // falling edge, after the driver and the monitor have acted on the
    // rising one.
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_q.size() != 0 || s_valid || expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Called at a rising edge with the block idle. The model takes the new
    // period once the configuration transfer has happened.
    task automatic write_period(input logic [15:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        period_cur = value;
    endtask

    // Input driver. A transfer happens at an edge where valid and ready were
    // both high; the item is handed to the drive model right then. A new
    // item, or a gap, is only started once the current one has moved on.
    always @(posedge aclk) begin
        dmpr_pkg::out_item_t predicted;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_item(s_item, predicted);
                expected_q.push_back(predicted);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    s_item   <= pending_q.pop_front();
                    s_valid  <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each result transfer is matched against the oldest
    // prediction, field by field. Ready drops for random stretches so that
    // stalls land on every stage of the pipeline.
    always @(posedge aclk) begin
        dmpr_pkg::out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_error($sformatf("result %0d arrived with nothing predicted",
                                           results_seen));
                end else begin
                    want = expected_q.pop_front();
                    check_field("left_compare", 32'(m_item.left_compare),
                                32'(want.left_compare));
                    check_field("right_compare", 32'(m_item.right_compare),
                                32'(want.right_compare));
                    check_field("left_enable", 32'(m_item.left_enable),
                                32'(want.left_enable));
                    check_field("right_enable", 32'(m_item.right_enable),
                                32'(want.right_enable));
                    check_field("left_forward_pin", 32'(m_item.left_forward_pin),
                                32'(want.left_forward_pin));
                    check_field("left_backward_pin", 32'(m_item.left_backward_pin),
                                32'(want.left_backward_pin));
                    check_field("right_forward_pin", 32'(m_item.right_forward_pin),
                                32'(want.right_forward_pin));
                    check_field("right_backward_pin", 32'(m_item.right_backward_pin),
                                32'(want.right_backward_pin));
                    check_field("ramp_busy", 32'(m_item.ramp_busy),
                                32'(want.ramp_busy));
                end
                results_seen++;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready   <= 1'b1;
                recv_hold = pick_gap();
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [15:0] phase_period [6];
        int unsigned first;

        // The largest period, a tiny one, a zero period, a period of 100 and two
        // random values. The reset value is used by the first phase.
        phase_period[0] = 16'hFFFF;
        phase_period[1] = 16'd1;
        phase_period[2] = 16'd0;
        phase_period[3] = 16'($urandom_range(2, 65534));
        phase_period[4] = 16'd100;
        phase_period[5] = 16'($urandom_range(2, 999));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening under the reset period. A tick with nothing to
        // move keeps busy low, and the unused kind changes nothing.
        enqueue(make_item(dmpr_pkg::KIND_TICK, dmpr_pkg::SEL_BOTH, 8'd0,
                          dmpr_pkg::DIR_FORWARD));
        enqueue(make_item(dmpr_pkg::KIND_UNUSED, dmpr_pkg::SEL_BOTH, 8'hFF,
                          dmpr_pkg::DIR_BACKWARD));
        // A goal with no motor selected still raises busy; the next tick
        // finds nothing to move and clears it.
        enqueue(make_item(dmpr_pkg::KIND_SET_TARGET, dmpr_pkg::SEL_NONE, 8'd50,
                          dmpr_pkg::DIR_FORWARD));
        enqueue(make_item(dmpr_pkg::KIND_TICK, dmpr_pkg::SEL_NONE, 8'd0,
                          dmpr_pkg::DIR_FORWARD));
        // Goals above full scale are clamped.
        enqueue(make_item(dmpr_pkg::KIND_SET_TARGET, dmpr_pkg::SEL_LEFT, 8'hFF,
                          dmpr_pkg::DIR_IGNORE));
        enqueue(make_item(dmpr_pkg::KIND_SET_TARGET, dmpr_pkg::SEL_RIGHT, 8'd101,
                          dmpr_pkg::DIR_STOP));
        enqueue(make_item(dmpr_pkg::KIND_SET_TARGET, dmpr_pkg::SEL_BOTH,
                          8'(dmpr_pkg::FULL_PERCENT), dmpr_pkg::DIR_FORWARD));
        enqueue(make_item(dmpr_pkg::KIND_TICK, dmpr_pkg::SEL_LEFT, 8'hAA,
                          dmpr_pkg::DIR_IGNORE));
        enqueue(make_item(dmpr_pkg::KIND_TICK, dmpr_pkg::SEL_RIGHT, 8'h55,
                          dmpr_pkg::DIR_STOP));
        // Ramp the left motor back down to zero so its enable drops.
        enqueue(make_item(dmpr_pkg::KIND_SET_TARGET, dmpr_pkg::SEL_LEFT, 8'd0,
                          dmpr_pkg::DIR_BACKWARD));
        enqueue(make_item(dmpr_pkg::KIND_TICK, dmpr_pkg::SEL_BOTH, 8'd0,
                          dmpr_pkg::DIR_FORWARD));
        enqueue(make_item(dmpr_pkg::KIND_TICK, dmpr_pkg::SEL_BOTH, 8'd0,
                          dmpr_pkg::DIR_FORWARD));
        enqueue(make_item(dmpr_pkg::KIND_TICK, dmpr_pkg::SEL_BOTH, 8'd0,
                          dmpr_pkg::DIR_FORWARD));
        // Every direction code and every selection appear, the ignored code and
        // the empty selection included.
        enqueue(make_item(dmpr_pkg::KIND_SET_DIR, dmpr_pkg::SEL_LEFT, 8'd0,
                          dmpr_pkg::DIR_FORWARD));
        enqueue(make_item(dmpr_pkg::KIND_SET_DIR, dmpr_pkg::SEL_RIGHT, 8'hFF,
                          dmpr_pkg::DIR_BACKWARD));
        enqueue(make_item(dmpr_pkg::KIND_SET_DIR, dmpr_pkg::SEL_NONE, 8'd0,
                          dmpr_pkg::DIR_STOP));
        enqueue(make_item(dmpr_pkg::KIND_SET_DIR, dmpr_pkg::SEL_BOTH, 8'd0,
                          dmpr_pkg::DIR_IGNORE));
        enqueue(make_item(dmpr_pkg::KIND_SET_DIR, dmpr_pkg::SEL_LEFT, 8'd0,
                          dmpr_pkg::DIR_BACKWARD));
        enqueue(make_item(dmpr_pkg::KIND_SET_DIR, dmpr_pkg::SEL_RIGHT, 8'd0,
                          dmpr_pkg::DIR_FORWARD));
        enqueue(make_item(dmpr_pkg::KIND_SET_DIR, dmpr_pkg::SEL_BOTH, 8'd0,
                          dmpr_pkg::DIR_STOP));
        enqueue(make_item(dmpr_pkg::KIND_SET_DIR, dmpr_pkg::SEL_BOTH, 8'd0,
                          dmpr_pkg::DIR_BACKWARD));
        enqueue(make_item(dmpr_pkg::KIND_SET_DIR, dmpr_pkg::SEL_RIGHT, 8'd0,
                          dmpr_pkg::DIR_STOP));
        enqueue(make_item(dmpr_pkg::KIND_UNUSED, dmpr_pkg::SEL_NONE, 8'd0,
                          dmpr_pkg::DIR_IGNORE));

        first = items_queued;
        while (items_queued - first < PHASE_ITEMS) queue_burst();
        wait_drained();

        // Each later phase first lets the block go fully idle, then changes
        // the period. Duty and goals carry over, so a compare only picks up
        // the new period when its channel next moves.
        for (int p = 0; p < 6; p++) begin
            steady_mode = (p == 3);
            write_period(phase_period[p]);
            first = items_queued;
            while (items_queued - first < PHASE_ITEMS) queue_burst();
            wait_drained();
        end

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
